[rtl/shrz_pkg.sv]
package shrz_pkg;

    localparam int COEF_WIDTH_DEF = 16;

    localparam int NBASIS      = 9;
    localparam int NCH         = 3;
    localparam int NSLOT       = 27;
    localparam int SLOT_W      = 5;
    localparam int VAL_W       = 16;
    localparam int ANG_W       = 16;
    localparam int CNT_W       = 16;
    // rotation factors: cos, -sin, and the double-angle terms (up to +-2^17)
    localparam int K_W         = 19;
    localparam int FRAC_K      = 14;
    // clamped dot product, 0..2^26
    localparam int CLAMP_W     = 27;
    localparam int COLOR_W     = 12;
    localparam int INV_PI_Q16  = 20861;
    localparam int INV_PI_W    = 15;
    localparam int COLOR_SHIFT = 28;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_COS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VCOUNT = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [SLOT_W-1:0]       env_slot;
        logic signed [VAL_W-1:0] env_value;
        logic signed [VAL_W-1:0] vis_0;
        logic signed [VAL_W-1:0] vis_1;
        logic signed [VAL_W-1:0] vis_2;
        logic signed [VAL_W-1:0] vis_3;
        logic signed [VAL_W-1:0] vis_4;
        logic signed [VAL_W-1:0] vis_5;
        logic signed [VAL_W-1:0] vis_6;
        logic signed [VAL_W-1:0] vis_7;
        logic signed [VAL_W-1:0] vis_8;
    } in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               frame_end;
    } out_t;

    // load enables of the pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } pipe_en_t;

endpackage

[rtl/sh_rotate_z_vertex_shade.sv]
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  shrz_pkg::in_t  (load or vertex)
// m_        out        m_valid / m_ready  shrz_pkg::out_t (color, frame_end)
// apb       in         psel / penable     cos_angle, sin_angle, vertex_count
//
// One transaction per cycle while s_ready is high; a vertex's color passes
// the rotate, multiply and two-level sum stages of each lane, then the 1/pi stage.
// A load updates the coefficient store and produces nothing.
// s_ready drops for one cycle after each register write (double-angle update).
// Reset clears the coefficients, the vertex index and all stage valids.
// Stalls on m_ready let empty stages fill, so input keeps flowing until full.
module sh_rotate_z_vertex_shade #(
    parameter int COEF_WIDTH = shrz_pkg::COEF_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  shrz_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output shrz_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shrz_pkg::ADDR_W-1:0]   paddr,
    input  logic [shrz_pkg::DATA_W-1:0]   pwdata,
    output logic [shrz_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NCH    = shrz_pkg::NCH;
    localparam int NB     = shrz_pkg::NBASIS;
    localparam int ANG_W  = shrz_pkg::ANG_W;
    localparam int CNT_W  = shrz_pkg::CNT_W;
    localparam int K_W    = shrz_pkg::K_W;
    localparam int STAGES = 5;

    logic [ANG_W-1:0]      cos_reg;
    logic [ANG_W-1:0]      sin_reg;
    logic [CNT_W-1:0]      vcount_reg;
    logic [CNT_W-1:0]      vidx_reg;
    logic [CNT_W-1:0]      vidx_next;
    logic                  hold_reg;
    logic [COEF_WIDTH-1:0] env_reg [shrz_pkg::NSLOT];
    logic signed [K_W-1:0] cos2_reg;
    logic signed [K_W-1:0] sin2_reg;
    logic [STAGES-1:0]     vld_reg;
    logic [STAGES-1:0]     vld_next;
    logic [STAGES-2:0]     last_reg;

    logic [shrz_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;
    logic                           s_acc;
    logic                           load_acc;
    logic                           last_now;
    logic signed [2*ANG_W:0]        cc_ss;
    logic signed [2*ANG_W+1:0]      cs2;
    shrz_pkg::pipe_en_t             en;

    logic [NB-1:0][COEF_WIDTH-1:0]                  env_lane [NCH];
    logic [NB-1:0][shrz_pkg::VAL_W-1:0]             vis_pk;
    logic [NCH-1:0][shrz_pkg::CLAMP_W-1:0]          lane_sum;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[shrz_pkg::ADDR_W-1:shrz_pkg::ADDR_W-shrz_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            shrz_pkg::REG_COS:    prdata = shrz_pkg::DATA_W'(cos_reg);
            shrz_pkg::REG_SIN:    prdata = shrz_pkg::DATA_W'(sin_reg);
            shrz_pkg::REG_VCOUNT: prdata = shrz_pkg::DATA_W'(vcount_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= ANG_W'(16384);
            sin_reg    <= '0;
            vcount_reg <= CNT_W'(1);
            hold_reg   <= 1'b0;
        end else begin
            hold_reg <= cfg_wr;
            if (cfg_wr) begin
                unique case (reg_idx)
                    shrz_pkg::REG_COS:    cos_reg    <= pwdata[ANG_W-1:0];
                    shrz_pkg::REG_SIN:    sin_reg    <= pwdata[ANG_W-1:0];
                    shrz_pkg::REG_VCOUNT: vcount_reg <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // double-angle terms, rounded half up to Q4.14
    always_comb begin
        cc_ss = $signed(cos_reg) * $signed(cos_reg) - $signed(sin_reg) * $signed(sin_reg)
              + $signed((2*ANG_W+1)'(1) << (shrz_pkg::FRAC_K - 1));
        cs2   = $signed(cos_reg) * $signed(sin_reg);
        cs2   = (cs2 <<< 1) + $signed((2*ANG_W+2)'(1) << (shrz_pkg::FRAC_K - 1));
    end

    always_ff @(posedge aclk) begin
        cos2_reg <= cc_ss[2*ANG_W:shrz_pkg::FRAC_K];
        sin2_reg <= cs2[2*ANG_W:shrz_pkg::FRAC_K];
    end

    // pipeline control, empty stages fill under output stall
    always_comb begin
        en.ld5   = vld_reg[3] && (!vld_reg[4] || m_ready);
        en.ld4   = vld_reg[2] && (!vld_reg[3] || en.ld5);
        en.ld3   = vld_reg[1] && (!vld_reg[2] || en.ld4);
        en.ld2   = vld_reg[0] && (!vld_reg[1] || en.ld3);
        s_ready  = (!vld_reg[0] || en.ld2) && !hold_reg;
        s_acc    = s_valid && s_ready;
        en.ld1   = s_acc && (s_data.req_type == shrz_pkg::REQ_SHADE);
        load_acc = s_acc && (s_data.req_type == shrz_pkg::REQ_LOAD);

        vld_next[0] = en.ld1 || (vld_reg[0] && !en.ld2);
        vld_next[1] = en.ld2 || (vld_reg[1] && !en.ld3);
        vld_next[2] = en.ld3 || (vld_reg[2] && !en.ld4);
        vld_next[3] = en.ld4 || (vld_reg[3] && !en.ld5);
        vld_next[4] = en.ld5 || (vld_reg[4] && !m_ready);
    end

    always_comb begin
        last_now  = ({1'b0, vidx_reg} + (CNT_W+1)'(1)) >= {1'b0, vcount_reg};
        vidx_next = last_now ? '0 : vidx_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vidx_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            if (en.ld1) begin
                vidx_reg <= vidx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld1) last_reg[0] <= last_now;
        if (en.ld2) last_reg[1] <= last_reg[0];
        if (en.ld3) last_reg[2] <= last_reg[1];
        if (en.ld4) last_reg[3] <= last_reg[2];
    end

    // coefficient store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < shrz_pkg::NSLOT; i++) begin
                env_reg[i] <= '0;
            end
        end else if (load_acc && (s_data.env_slot < shrz_pkg::SLOT_W'(shrz_pkg::NSLOT))) begin
            env_reg[s_data.env_slot] <= COEF_WIDTH'(s_data.env_value);
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int b = 0; b < NB; b++) begin
                env_lane[ch][b] = env_reg[b*NCH + ch];
            end
        end
        vis_pk[0] = s_data.vis_0;
        vis_pk[1] = s_data.vis_1;
        vis_pk[2] = s_data.vis_2;
        vis_pk[3] = s_data.vis_3;
        vis_pk[4] = s_data.vis_4;
        vis_pk[5] = s_data.vis_5;
        vis_pk[6] = s_data.vis_6;
        vis_pk[7] = s_data.vis_7;
        vis_pk[8] = s_data.vis_8;
    end

    for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
        shrz_lane #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_lane (
            .aclk   (aclk),
            .en     (en),
            .cos_i  ($signed(cos_reg)),
            .sin_i  ($signed(sin_reg)),
            .cos2_i (cos2_reg),
            .sin2_i (sin2_reg),
            .env_i  (env_lane[ch]),
            .vis_i  (vis_pk),
            .sum_o  (lane_sum[ch])
        );
    end

    shrz_merge u_merge (
        .aclk   (aclk),
        .en_i   (en.ld5),
        .sum_i  (lane_sum),
        .last_i (last_reg[3]),
        .data_o (m_data)
    );

    assign m_valid = vld_reg[4];

`ifndef SYNTHESIS
    a_hold_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input accepted right after a register write");

    a_only_vertex_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vld_reg[0]) |-> $past(en.ld1))
        else $error("first stage filled without a vertex transaction");

    a_index_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (en.ld1 && last_now) |=> (vidx_reg == '0))
        else $error("vertex index did not return to zero at frame end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending color changed under stall");
`endif

endmodule

[rtl/shrz_lane.sv]
module shrz_lane #(
    parameter int COEF_WIDTH = shrz_pkg::COEF_WIDTH_DEF
) (
    input  logic                                                 aclk,
    input  shrz_pkg::pipe_en_t                                   en,
    input  logic signed [shrz_pkg::ANG_W-1:0]                    cos_i,
    input  logic signed [shrz_pkg::ANG_W-1:0]                    sin_i,
    input  logic signed [shrz_pkg::K_W-1:0]                      cos2_i,
    input  logic signed [shrz_pkg::K_W-1:0]                      sin2_i,
    input  logic [shrz_pkg::NBASIS-1:0][COEF_WIDTH-1:0]          env_i,
    input  logic [shrz_pkg::NBASIS-1:0][shrz_pkg::VAL_W-1:0]     vis_i,
    output logic [shrz_pkg::CLAMP_W-1:0]                         sum_o
);

    localparam int K_W    = shrz_pkg::K_W;
    localparam int PW     = K_W + COEF_WIDTH;
    localparam int RW     = PW + 1 - shrz_pkg::FRAC_K;
    localparam int MW     = RW + shrz_pkg::VAL_W;
    localparam int GROUPS = shrz_pkg::NBASIS / 3;
    localparam int GW     = MW + 2;
    localparam int DW     = GW + 2;
    localparam logic signed [DW-1:0] CLAMP_HI = DW'(64'd1 << (shrz_pkg::CLAMP_W - 1));

    function automatic logic signed [RW-1:0] rot(
        input logic signed [K_W-1:0]        k1,
        input logic signed [COEF_WIDTH-1:0] x,
        input logic signed [K_W-1:0]        k2,
        input logic signed [COEF_WIDTH-1:0] y
    );
        logic signed [PW:0] half;
        logic signed [PW:0] acc;
        half = '0;
        half[shrz_pkg::FRAC_K-1] = 1'b1;
        acc = k1 * x + k2 * y + half;
        return acc[PW:shrz_pkg::FRAC_K];
    endfunction

    logic signed [K_W-1:0]          c_k;
    logic signed [K_W-1:0]          s_k;
    logic signed [K_W-1:0]          ns_k;
    logic signed [K_W-1:0]          ns2_k;
    logic signed [COEF_WIDTH-1:0]   e [shrz_pkg::NBASIS];
    logic signed [RW-1:0]           r_next [shrz_pkg::NBASIS];

    logic signed [RW-1:0]             r_reg   [shrz_pkg::NBASIS];
    logic signed [shrz_pkg::VAL_W-1:0] vis_reg [shrz_pkg::NBASIS];
    logic signed [MW-1:0]             m_reg   [shrz_pkg::NBASIS];
    logic signed [GW-1:0]             g_reg   [GROUPS];
    logic signed [DW-1:0]             total;
    logic [shrz_pkg::CLAMP_W-1:0]     sum_next;
    logic [shrz_pkg::CLAMP_W-1:0]     sum_reg;

    always_comb begin
        c_k   = K_W'(cos_i);
        s_k   = K_W'(sin_i);
        ns_k  = -s_k;
        ns2_k = -sin2_i;
        for (int b = 0; b < shrz_pkg::NBASIS; b++) begin
            e[b] = $signed(env_i[b]);
        end
        r_next[0] = RW'(e[0]);
        r_next[1] = rot(c_k, e[1], s_k, e[3]);
        r_next[2] = RW'(e[2]);
        r_next[3] = rot(ns_k, e[1], c_k, e[3]);
        r_next[4] = rot(cos2_i, e[4], sin2_i, e[8]);
        r_next[5] = rot(c_k, e[5], s_k, e[7]);
        r_next[6] = RW'(e[6]);
        r_next[7] = rot(ns_k, e[5], c_k, e[7]);
        r_next[8] = rot(ns2_k, e[4], cos2_i, e[8]);
    end

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            for (int b = 0; b < shrz_pkg::NBASIS; b++) begin
                r_reg[b]   <= r_next[b];
                vis_reg[b] <= $signed(vis_i[b]);
            end
        end
        if (en.ld2) begin
            for (int b = 0; b < shrz_pkg::NBASIS; b++) begin
                m_reg[b] <= r_reg[b] * vis_reg[b];
            end
        end
        if (en.ld3) begin
            for (int j = 0; j < GROUPS; j++) begin
                g_reg[j] <= m_reg[3*j] + m_reg[3*j+1] + m_reg[3*j+2];
            end
        end
        if (en.ld4) begin
            sum_reg <= sum_next;
        end
    end

    always_comb begin
        total = '0;
        for (int j = 0; j < GROUPS; j++) begin
            total = total + DW'(g_reg[j]);
        end
        if (total < 0) begin
            sum_next = '0;
        end else if (total > CLAMP_HI) begin
            sum_next = shrz_pkg::CLAMP_W'(CLAMP_HI);
        end else begin
            sum_next = total[shrz_pkg::CLAMP_W-1:0];
        end
    end

    assign sum_o = sum_reg;

endmodule

[rtl/shrz_merge.sv]
module shrz_merge (
    input  logic                                             aclk,
    input  logic                                             en_i,
    input  logic [shrz_pkg::NCH-1:0][shrz_pkg::CLAMP_W-1:0]  sum_i,
    input  logic                                             last_i,
    output shrz_pkg::out_t                                   data_o
);

    localparam int PROD_W = shrz_pkg::CLAMP_W + shrz_pkg::INV_PI_W + 1;
    localparam int C_LO   = shrz_pkg::COLOR_SHIFT;
    localparam int C_HI   = shrz_pkg::COLOR_SHIFT + shrz_pkg::COLOR_W;

    function automatic logic [shrz_pkg::COLOR_W-1:0] to_color(
        input logic [shrz_pkg::CLAMP_W-1:0] v
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(v) * PROD_W'(shrz_pkg::INV_PI_Q16) + (PROD_W'(1) << (C_LO - 1));
        if (|p[PROD_W-1:C_HI]) begin
            return '1;
        end
        return p[C_HI-1:C_LO];
    endfunction

    shrz_pkg::out_t data_next;
    shrz_pkg::out_t data_reg;

    always_comb begin
        data_next.red       = to_color(sum_i[0]);
        data_next.green     = to_color(sum_i[1]);
        data_next.blue      = to_color(sum_i[2]);
        data_next.frame_end = last_i;
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            data_reg <= data_next;
        end
    end

    assign data_o = data_reg;

endmodule

[test/tb_top.sv]
module tb_top;

    localparam int REG_IDX_W   = shrz_pkg::REG_IDX_W;
    localparam int ADDR_W      = shrz_pkg::ADDR_W;
    localparam int DATA_W      = shrz_pkg::DATA_W;
    localparam int VAL_W       = shrz_pkg::VAL_W;
    localparam int ANG_W       = shrz_pkg::ANG_W;
    localparam int CNT_W       = shrz_pkg::CNT_W;
    localparam int NSLOT       = shrz_pkg::NSLOT;
    localparam int NBASIS      = shrz_pkg::NBASIS;
    localparam int NCH         = shrz_pkg::NCH;
    localparam int SLOT_W      = shrz_pkg::SLOT_W;
    localparam int FRAC_K      = shrz_pkg::FRAC_K;
    localparam int COLOR_W     = shrz_pkg::COLOR_W;
    localparam int INV_PI_Q16  = shrz_pkg::INV_PI_Q16;
    localparam int COLOR_SHIFT = shrz_pkg::COLOR_SHIFT;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    shrz_pkg::in_t       s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    shrz_pkg::out_t      m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sh_rotate_z_vertex_shade dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shading state mirrored from the block
    logic signed [VAL_W-1:0] env_coef [NSLOT];
    logic signed [ANG_W-1:0] cfg_cos = 16'sd16384;
    logic signed [ANG_W-1:0] cfg_sin = 16'sd0;
    logic [CNT_W-1:0]        cfg_vcount = 16'd1;
    logic [CNT_W-1:0]        vtx_idx = 16'd0;

    shrz_pkg::in_t  pending [$];
    shrz_pkg::out_t exp_colors [$];
    int   fail_cnt = 0;

    bit src_gaps = 1'b0;
    bit snk_stalls = 1'b0;
    bit hold_req = 1'b0;

    initial begin
        for (int i = 0; i < NSLOT; i++) env_coef[i] = '0;
    end

    function automatic longint rnd14(input longint v);
        return (v + 64'sd8192) >>> FRAC_K;
    endfunction

    function automatic logic [COLOR_W-1:0] to_color(input longint sum);
        longint v;
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 26)) sum = longint'(1) << 26;
        v = (sum * INV_PI_Q16 + (longint'(1) << 27)) >>> COLOR_SHIFT;
        if (v > 4095) v = 4095;
        return v[COLOR_W-1:0];
    endfunction

    // load updates the coefficient store, vertex yields one expected color
    function automatic void apply_request(input shrz_pkg::in_t t);
        longint c, s, c2, s2;
        longint e [NBASIS];
        longint r [NBASIS];
        longint vis [NBASIS];
        longint sum [NCH];
        logic signed [VAL_W-1:0] vf [NBASIS];
        shrz_pkg::out_t o;
        bit last;
        if (t.req_type == shrz_pkg::REQ_LOAD) begin
            if (t.env_slot < NSLOT) env_coef[t.env_slot] = t.env_value;
            return;
        end
        c = cfg_cos;
        s = cfg_sin;
        c2 = rnd14(c * c - s * s);
        s2 = rnd14(2 * c * s);
        vf = '{t.vis_0, t.vis_1, t.vis_2, t.vis_3, t.vis_4,
               t.vis_5, t.vis_6, t.vis_7, t.vis_8};
        for (int b = 0; b < NBASIS; b++) vis[b] = vf[b];
        for (int ch = 0; ch < NCH; ch++) begin
            for (int b = 0; b < NBASIS; b++) e[b] = env_coef[b * NCH + ch];
            r[0] = e[0];
            r[1] = rnd14(c * e[1] + s * e[3]);
            r[2] = e[2];
            r[3] = rnd14(-s * e[1] + c * e[3]);
            r[4] = rnd14(c2 * e[4] + s2 * e[8]);
            r[5] = rnd14(c * e[5] + s * e[7]);
            r[6] = e[6];
            r[7] = rnd14(-s * e[5] + c * e[7]);
            r[8] = rnd14(-s2 * e[4] + c2 * e[8]);
            sum[ch] = 0;
            for (int b = 0; b < NBASIS; b++) sum[ch] += r[b] * vis[b];
        end
        last = ({16'd0, vtx_idx} + 32'd1) >= {16'd0, cfg_vcount};
        vtx_idx = last ? 16'd0 : vtx_idx + 16'd1;
        o.red = to_color(sum[0]);
        o.green = to_color(sum[1]);
        o.blue = to_color(sum[2]);
        o.frame_end = last;
        exp_colors.push_back(o);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    int src_wait = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_request(s_data);
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    s_data <= pending.pop_front();
                    s_valid <= 1'b1;
                    src_wait = src_gaps ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int expv, input int act);
        if (expv != act) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, act);
            fail_cnt++;
        end
    endtask

    // monitor
    int  snk_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        shrz_pkg::out_t want;
        bit   rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (exp_colors.size() == 0) begin
                    $display("%0t: unexpected transaction, got %h", $time, m_data);
                    fail_cnt++;
                end else begin
                    want = exp_colors.pop_front();
                    check_field("red", want.red, m_data.red);
                    check_field("green", want.green, m_data.green);
                    check_field("blue", want.blue, m_data.blue);
                    check_field("frame_end", want.frame_end, m_data.frame_end);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (snk_stalls && $urandom_range(0, 2) == 0) snk_wait = pick_gap();
            end
            m_ready <= rdy;
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
        logic [DATA_W-1:0] word;
        word = {16'($urandom), val};
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            shrz_pkg::REG_COS:    cfg_cos = word[15:0];
            shrz_pkg::REG_SIN:    cfg_sin = word[15:0];
            shrz_pkg::REG_VCOUNT: cfg_vcount = word[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending.size() != 0 || s_valid || exp_colors.size() != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic shrz_pkg::in_t rand_raw();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(shrz_pkg::in_t)-1:0];
    endfunction

    function automatic logic [15:0] rand_q12();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 8192) - 4096);
    endfunction

    function automatic shrz_pkg::in_t mk_load(input int slot, input int val);
        shrz_pkg::in_t t;
        t = rand_raw();
        t.req_type = shrz_pkg::REQ_LOAD;
        t.env_slot = slot[SLOT_W-1:0];
        t.env_value = val[VAL_W-1:0];
        return t;
    endfunction

    function automatic shrz_pkg::in_t shade_one(input int basis, input int val,
                                                input int rest);
        shrz_pkg::in_t t;
        logic [15:0] vf [NBASIS];
        t = rand_raw();
        t.req_type = shrz_pkg::REQ_SHADE;
        for (int b = 0; b < NBASIS; b++) vf[b] = (b == basis) ? val[15:0] : rest[15:0];
        {t.vis_0, t.vis_1, t.vis_2, t.vis_3, t.vis_4, t.vis_5, t.vis_6, t.vis_7, t.vis_8} =
            {vf[0], vf[1], vf[2], vf[3], vf[4], vf[5], vf[6], vf[7], vf[8]};
        return t;
    endfunction

    function automatic shrz_pkg::in_t shade_rand();
        shrz_pkg::in_t t;
        t = rand_raw();
        t.req_type = shrz_pkg::REQ_SHADE;
        {t.vis_0, t.vis_1, t.vis_2, t.vis_3, t.vis_4, t.vis_5, t.vis_6, t.vis_7, t.vis_8} =
            {rand_q12(), rand_q12(), rand_q12(), rand_q12(), rand_q12(),
             rand_q12(), rand_q12(), rand_q12(), rand_q12()};
        return t;
    endfunction

    initial begin
        #20_000_000;
        $display("** sh_rotate_z_vertex_shade: FAILED **");
        $finish;
    end

    initial begin
        int   order [NSLOT];
        int   j, tmp, n, p, sel;
        real  ang;
        logic [15:0] cv, sv, vc;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: identity rotation, one vertex per frame
        pending.push_back(shade_one(0, 32767, 32767));
        pending.push_back(mk_load(0, 32767));
        pending.push_back(mk_load(31, 1234));
        pending.push_back(mk_load(27, -1));
        pending.push_back(mk_load(26, -32768));
        pending.push_back(mk_load(1, 4096));
        pending.push_back(mk_load(5, 2048));
        pending.push_back(mk_load(12, 3000));
        pending.push_back(mk_load(24, -2000));
        pending.push_back(mk_load(11, 1500));
        pending.push_back(shade_one(0, 4096, 0));
        pending.push_back(shade_one(1, 4096, 0));
        pending.push_back(shade_one(0, -32768, -32768));
        pending.push_back(shade_one(4, 4096, 0));
        pending.push_back(shade_one(8, 32767, 0));
        drain();

        // quarter turn, zero vertex count
        reg_write(shrz_pkg::REG_COS, 16'd0);
        reg_write(shrz_pkg::REG_SIN, 16'd16384);
        reg_write(shrz_pkg::REG_VCOUNT, 16'd0);
        pending.push_back(shade_one(1, 4096, 0));
        pending.push_back(shade_one(3, 4096, 0));
        pending.push_back(shade_one(4, -4096, 0));
        drain();

        // out-of-range angle terms, longest frame
        reg_write(shrz_pkg::REG_COS, 16'h8000);
        reg_write(shrz_pkg::REG_SIN, 16'h7FFF);
        reg_write(shrz_pkg::REG_VCOUNT, 16'hFFFF);
        reg_write(REG_UNUSED, 16'h0005);
        repeat (4) pending.push_back(shade_rand());
        drain();

        // count drops below the running index
        reg_write(shrz_pkg::REG_COS, 16'h7FFF);
        reg_write(shrz_pkg::REG_SIN, 16'h8000);
        reg_write(shrz_pkg::REG_VCOUNT, 16'd2);
        pending.push_back(shade_rand());
        pending.push_back(shade_rand());
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                ang = $urandom_range(0, 62831) / 10000.0;
                cv = 16'($rtoi(16384.0 * $cos(ang)));
                sv = 16'($rtoi(16384.0 * $sin(ang)));
            end else if (sel < 7) begin
                cv = 16'($urandom_range(0, 2) * 16384 - 16384);
                sv = (cv == 16'd0) ? 16'($urandom_range(0, 1) * 32768 - 16384) : 16'd0;
            end else begin
                cv = 16'($urandom);
                sv = 16'($urandom);
            end
            p = $urandom_range(0, 99);
            if (p < 60) vc = 16'($urandom_range(1, 8));
            else if (p < 75) vc = 16'd1;
            else if (p < 85) vc = 16'd0;
            else if (p < 95) vc = 16'($urandom_range(1, 300));
            else vc = 16'hFFFF;
            reg_write(shrz_pkg::REG_COS, cv);
            reg_write(shrz_pkg::REG_SIN, sv);
            reg_write(shrz_pkg::REG_VCOUNT, vc);

            sel = $urandom_range(0, 3);
            src_gaps = sel[0];
            snk_stalls = sel[1];
            if (ph == 2) begin
                src_gaps = 1'b0;
                hold_req = 1'b1;
            end

            for (int i = 0; i < NSLOT; i++) order[i] = i;
            for (int i = 0; i < NSLOT - 1; i++) begin
                j = $urandom_range(i, NSLOT - 1);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < NSLOT; i++) pending.push_back(mk_load(order[i], rand_q12()));

            n = $urandom_range(180, 240);
            repeat (n) begin
                p = $urandom_range(0, 99);
                if (p < 86) pending.push_back(shade_rand());
                else if (p < 95) pending.push_back(mk_load($urandom_range(0, NSLOT - 1),
                                                           rand_q12()));
                else pending.push_back(mk_load($urandom_range(NSLOT, 31), rand_q12()));
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_cnt == 0 && exp_colors.size() == 0) begin
            $display("** sh_rotate_z_vertex_shade: PASSED **");
        end else begin
            $display("** sh_rotate_z_vertex_shade: FAILED **");
        end
        $finish;
    end

endmodule

[sh_rotate_z_vertex_shade.f]
rtl/shrz_pkg.sv
rtl/shrz_lane.sv
rtl/shrz_merge.sv
rtl/sh_rotate_z_vertex_shade.sv
test/tb_top.sv
